@@ rtl/silu_fb_pkg.sv @@
`timescale 1ns / 1ps

package silu_fb_pkg;

  // word format
  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 8;

  // request codes
  localparam logic REQ_FWD = 1'b0;
  localparam logic REQ_BWD = 1'b1;

  // exponential and sigmoid datapath
  localparam int unsigned TAYLOR_TERMS = 14;
  localparam int unsigned SIG_BITS     = 31;
  localparam int unsigned CLAMP_MAG    = 30;
  localparam logic [31:0] LN2_Q32      = 32'hB17217F8;
  // floor(2^48 / ln2_q32), used to estimate the ln2 multiple
  localparam logic [16:0] LN2_RECIP    = 17'(49'h1_0000_0000_0000 / 49'(LN2_Q32));
  localparam logic [SIG_BITS-1:0] SIG_ONE = SIG_BITS'(1) << (SIG_BITS - 1);

  // saturation limits
  localparam logic signed [63:0] DATA_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] DATA_MIN = -(64'sd1 <<< (DATA_WIDTH - 1));
  localparam logic signed [63:0] D32_MAX  = (64'sd1 <<< 31) - 64'sd1;
  localparam logic signed [63:0] D32_MIN  = -(64'sd1 <<< 31);

  typedef struct packed {
    logic                         req_type;
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] grad_in;
    logic                         in_last;
  } req_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic                         out_last;
  } rsp_word_t;

  // series evaluation stage contents
  typedef struct packed {
    logic [5:0]  n;
    logic [31:0] r;
    logic [32:0] sum;
    logic [31:0] t;
    logic [31:0] v;
  } tay_t;

  // long division stage contents
  typedef struct packed {
    logic [33:0]         den;
    logic [33:0]         rem;
    logic [SIG_BITS-1:0] q;
  } div_t;

  // round to nearest, ties away from zero, then shift right
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] rr;
    neg = v[63];
    mag = neg ? 64'(-v) : 64'(v);
    rr  = (mag + (64'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(rr) : $signed(rr);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > DATA_MAX) begin
      c = DATA_MAX;
    end else if (v < DATA_MIN) begin
      c = DATA_MIN;
    end else begin
      c = v;
    end
    return c[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] sat_d32(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > D32_MAX) begin
      c = D32_MAX;
    end else if (v < D32_MIN) begin
      c = D32_MIN;
    end else begin
      c = v;
    end
    return c[31:0];
  endfunction

endpackage

@@ rtl/silu_activation_fwd_bwd_core.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake            | word
// req     | in        | req_valid, req_ready | req_word_t: req_type, x_value, grad_in, in_last
// rsp     | out       | rsp_valid, rsp_ready | rsp_word_t: result_value, out_last
//
// one word per cycle sustained while the skid slot is empty
// the pipeline holds the 13 series steps (3 stages each) and the 31-stage sigmoid divider
// rst clears the stage valid bits, the output register and the skid slot
// a word produced while the output stalls parks in the skid slot; the pipeline freezes only while it is full

module silu_activation_fwd_bwd_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  silu_fb_pkg::req_word_t req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output silu_fb_pkg::rsp_word_t rsp
);

  localparam int unsigned DW      = silu_fb_pkg::DATA_WIDTH;
  localparam int unsigned FB      = silu_fb_pkg::FRAC_BITS;
  localparam int unsigned SB      = silu_fb_pkg::SIG_BITS;
  localparam int unsigned TAY_LEN = 3 * (silu_fb_pkg::TAYLOR_TERMS - 1);
  localparam int unsigned ST_TAY0 = 4;
  localparam int unsigned ST_DIV0 = ST_TAY0 + TAY_LEN + 1;
  localparam int unsigned ST_P1   = ST_DIV0 + SB + 1;
  localparam int unsigned NSTG    = ST_P1 + 6;
  localparam int unsigned FP_W    = DW + 32;
  localparam int unsigned XQ_W    = DW + 30;
  localparam int unsigned GD_W    = DW + 32;
  localparam logic signed [39:0] CLAMP_HI = 40'(silu_fb_pkg::CLAMP_MAG) << FB;
  localparam logic signed [39:0] CLAMP_LO = -CLAMP_HI;

  // pipeline control and word sideband
  logic                   pipe_en;
  logic                   produced;
  logic                   vld  [1:NSTG];
  silu_fb_pkg::req_word_t meta [1:NSTG];

  // range reduction
  logic signed [39:0] x_w;
  logic signed [39:0] x_clamp;
  logic [39:0]        a_w;
  logic [36:0]        a32_next;
  logic [37:0]        np;
  logic [36:0]        r0_w;
  logic [36:0]        a32_s1;
  logic [36:0]        a32_s2;
  logic [5:0]         n0_s2;
  logic [32:0]        r0_s3;
  logic [5:0]         n0_s3;
  silu_fb_pkg::tay_t  tay0_next;
  silu_fb_pkg::tay_t  tay [0:TAY_LEN];

  // sigmoid divider
  silu_fb_pkg::div_t  div0_next;
  silu_fb_pkg::div_t  dv [0:SB];
  logic [32:0]        e_val;

  // output arithmetic
  logic [SB-1:0]            s_next;
  logic signed [FP_W-1:0]   fp_next;
  logic [2*SB-1:0]          sq_next;
  logic signed [DW-1:0]     fwd_next;
  logic [28:0]              q_next;
  logic signed [XQ_W-1:0]   xq_next;
  logic signed [63:0]       dsum;
  logic signed [31:0]       d_next;
  logic signed [GD_W-1:0]   gd_next;
  logic signed [DW-1:0]     res_next;
  logic [SB-1:0]            s_p1, s_p2, s_p3, s_p4;
  logic signed [FP_W-1:0]   fp_p2;
  logic [2*SB-1:0]          sq_p2;
  logic signed [DW-1:0]     fwd_p3, fwd_p4, fwd_p5, fwd_p6;
  logic [28:0]              q_p3;
  logic signed [XQ_W-1:0]   xq_p4;
  logic signed [31:0]       d_p5;
  logic signed [GD_W-1:0]   gd_p6;
  logic signed [DW-1:0]     res_p7;

  // output register and skid slot
  logic                   skid_valid;
  silu_fb_pkg::rsp_word_t skid_word;
  silu_fb_pkg::rsp_word_t last_word;

  assign pipe_en   = !skid_valid;
  assign req_ready = pipe_en;
  assign produced  = pipe_en && vld[NSTG];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NSTG; i++) vld[i] <= 1'b0;
    end else if (pipe_en) begin
      vld[1] <= req_valid;
      for (int i = 2; i <= NSTG; i++) vld[i] <= vld[i-1];
    end
  end

  // sideband travels with the data
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      meta[1] <= req;
      for (int i = 2; i <= NSTG; i++) meta[i] <= meta[i-1];
    end
  end

  // clamp, magnitude, ln2 multiple and remainder
  always_comb begin
    x_w = 40'($signed(req.x_value));
    if (x_w > CLAMP_HI) begin
      x_clamp = CLAMP_HI;
    end else if (x_w < CLAMP_LO) begin
      x_clamp = CLAMP_LO;
    end else begin
      x_clamp = x_w;
    end
    a_w      = x_clamp[39] ? 40'(-x_clamp) : 40'(x_clamp);
    a32_next = 37'(a_w << (32 - FB));
    np       = 38'(a32_s1[36:16]) * 38'(silu_fb_pkg::LN2_RECIP);
    r0_w     = a32_s2 - 37'(n0_s2) * 37'(silu_fb_pkg::LN2_Q32);

    // estimate is low by at most one ln2
    tay0_next.v = '0;
    if (r0_s3 >= 33'(silu_fb_pkg::LN2_Q32)) begin
      tay0_next.n = n0_s3 + 6'd1;
      tay0_next.r = 32'(r0_s3 - 33'(silu_fb_pkg::LN2_Q32));
    end else begin
      tay0_next.n = n0_s3;
      tay0_next.r = r0_s3[31:0];
    end
    tay0_next.t   = tay0_next.r;
    tay0_next.sum = 33'h1_0000_0000 - 33'(tay0_next.r);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a32_s1 <= a32_next;
      a32_s2 <= a32_s1;
      n0_s2  <= np[37:32];
      r0_s3  <= r0_w[32:0];
      n0_s3  <= n0_s2;
      tay[0] <= tay0_next;
    end
  end

  // series terms: multiply by r, divide by k, accumulate with alternating sign
  for (genvar gi = 0; gi < int'(silu_fb_pkg::TAYLOR_TERMS) - 1; gi++) begin : g_tay
    localparam logic [3:0]  KB    = 4'(gi + 2);
    localparam logic [31:0] RECIP = 32'(33'h1_0000_0000 / 33'(gi + 2));

    logic [63:0]       pa;
    logic [63:0]       pb;
    logic [35:0]       rem;
    logic [31:0]       qv;
    silu_fb_pkg::tay_t sa_next;
    silu_fb_pkg::tay_t sb_next;
    silu_fb_pkg::tay_t sc_next;

    always_comb begin
      pa        = 64'(tay[3*gi].t) * 64'(tay[3*gi].r);
      sa_next   = tay[3*gi];
      sa_next.t = pa[63:32];

      pb        = 64'(tay[3*gi+1].t) * 64'(RECIP);
      sb_next   = tay[3*gi+1];
      sb_next.v = tay[3*gi+1].t;
      sb_next.t = pb[63:32];

      // reciprocal quotient is low by at most one
      rem = 36'(tay[3*gi+2].v) - 36'(tay[3*gi+2].t) * 36'(KB);
      qv  = (rem >= 36'(KB)) ? tay[3*gi+2].t + 32'd1 : tay[3*gi+2].t;
      sc_next   = tay[3*gi+2];
      sc_next.t = qv;
      if (KB[0]) begin
        sc_next.sum = tay[3*gi+2].sum - 33'(qv);
      end else begin
        sc_next.sum = tay[3*gi+2].sum + 33'(qv);
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        tay[3*gi+1] <= sa_next;
        tay[3*gi+2] <= sb_next;
        tay[3*gi+3] <= sc_next;
      end
    end
  end

  // scale by 2^-n and set up 2^62 / (1 + e)
  always_comb begin
    e_val         = tay[TAY_LEN].sum >> tay[TAY_LEN].n;
    div0_next.den = 34'h1_0000_0000 + 34'(e_val);
    div0_next.rem = 34'h0_8000_0000;
    div0_next.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dv[0] <= div0_next;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar gj = 1; gj <= int'(SB); gj++) begin : g_div
    logic [34:0]       r2;
    silu_fb_pkg::div_t d_next_st;

    always_comb begin
      r2            = {dv[gj-1].rem, 1'b0};
      d_next_st.den = dv[gj-1].den;
      if (r2 >= 35'(dv[gj-1].den)) begin
        d_next_st.rem = 34'(r2 - 35'(dv[gj-1].den));
        d_next_st.q   = {dv[gj-1].q[SB-2:0], 1'b1};
      end else begin
        d_next_st.rem = r2[33:0];
        d_next_st.q   = {dv[gj-1].q[SB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dv[gj] <= d_next_st;
      end
    end
  end

  // sign fold, products, rounding and saturation
  always_comb begin
    s_next = meta[ST_P1-1].x_value[DW-1] ? silu_fb_pkg::SIG_ONE - dv[SB].q : dv[SB].q;

    fp_next = FP_W'(meta[ST_P1].x_value) * FP_W'($signed({1'b0, s_p1}));
    sq_next = (2*SB)'(s_p1) * (2*SB)'(silu_fb_pkg::SIG_ONE - s_p1);

    fwd_next = silu_fb_pkg::sat_data(silu_fb_pkg::rnd_shift(64'(fp_p2), 30));
    q_next   = 29'((sq_p2 + ((2*SB)'(1) << 29)) >> 30);

    xq_next = XQ_W'(meta[ST_P1+2].x_value) * XQ_W'($signed({1'b0, q_p3}));

    dsum   = 64'(xq_p4) + $signed(64'(s_p4) << FB);
    d_next = silu_fb_pkg::sat_d32(silu_fb_pkg::rnd_shift(dsum, FB));

    gd_next = GD_W'(meta[ST_P1+4].grad_in) * GD_W'(d_p5);

    if (meta[ST_P1+5].req_type == silu_fb_pkg::REQ_BWD) begin
      res_next = silu_fb_pkg::sat_data(silu_fb_pkg::rnd_shift(64'(gd_p6), 30));
    end else begin
      res_next = fwd_p6;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s_p1   <= s_next;
      fp_p2  <= fp_next;
      sq_p2  <= sq_next;
      s_p2   <= s_p1;
      fwd_p3 <= fwd_next;
      q_p3   <= q_next;
      s_p3   <= s_p2;
      xq_p4  <= xq_next;
      s_p4   <= s_p3;
      fwd_p4 <= fwd_p3;
      d_p5   <= d_next;
      fwd_p5 <= fwd_p4;
      gd_p6  <= gd_next;
      fwd_p6 <= fwd_p5;
      res_p7 <= res_next;
    end
  end

  assign last_word.result_value = res_p7;
  assign last_word.out_last     = meta[NSTG].in_last;

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_valid && !rsp_ready) begin
      if (produced) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      rsp_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      rsp_valid <= produced;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && !rsp_ready) begin
      if (produced) skid_word <= last_word;
    end else if (skid_valid) begin
      rsp <= skid_word;
    end else if (produced) begin
      rsp <= last_word;
    end
  end

endmodule

@@ rtl/silu_fb_checker.sv @@
`timescale 1ns / 1ps

module silu_fb_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input silu_fb_pkg::req_word_t req,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input silu_fb_pkg::rsp_word_t rsp
);

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("rsp word changed or dropped while stalled");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!rsp_valid && req_ready))
    else $error("block not empty after reset");

  // input side only blocks when a result word is waiting
  a_block_needs_rsp: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("req_ready low with no rsp word pending");

  // blocked input stays blocked until the output moves
  a_block_holds: assert property (@(posedge clk) disable iff (rst)
    (!req_ready && !rsp_ready) |=> !req_ready)
    else $error("req_ready rose without the output draining");

  // output draining reopens the input
  a_block_clears: assert property (@(posedge clk) disable iff (rst)
    (!req_ready && rsp_ready) |=> req_ready)
    else $error("req_ready stayed low after output drained");

endmodule

bind silu_activation_fwd_bwd_core silu_fb_checker u_silu_fb_checker (.*);
